/* rtl/core/mwpg_pkg.sv */
`timescale 1ns / 1ps
package mwpg_pkg;

    // field widths
    localparam int ELAPSED_W = 16;
    localparam int SAMPLE_W  = 16;
    localparam int AMP_W     = 15;
    localparam int STEP_W    = 9;
    localparam int PERIOD_W  = 24;
    localparam int TIMER_W   = 32;
    localparam int PHASE_W   = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_STEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRI_STEP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_STEP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD      = 3'd5;

    // register reset values
    localparam logic [AMP_W-1:0]    RST_AMPLITUDE = 15'd55;
    localparam logic [STEP_W-1:0]   RST_SLOW_STEP = 9'd5;
    localparam logic [STEP_W-1:0]   RST_FAST_STEP = 9'd14;
    localparam logic [STEP_W-1:0]   RST_TRI_STEP  = 9'd5;
    localparam logic [STEP_W-1:0]   RST_SQR_STEP  = 9'd5;
    localparam logic [PERIOD_W-1:0] RST_PERIOD    = 24'd8000;

    typedef enum logic [1:0] {
        MODE_SLOW_SINE = 2'd0,
        MODE_FAST_SINE = 2'd1,
        MODE_TRIANGLE  = 2'd2,
        MODE_SQUARE    = 2'd3
    } t_wave;

    typedef struct packed {
        logic [AMP_W-1:0]    amplitude;
        logic [STEP_W-1:0]   slow_step;
        logic [STEP_W-1:0]   fast_step;
        logic [STEP_W-1:0]   tri_step;
        logic [STEP_W-1:0]   square_step;
        logic [PERIOD_W-1:0] period;
    } t_cfg;

    // pipeline handshake controls
    typedef struct packed {
        logic s1_load;
        logic s2_load;
        logic s3_load;
    } t_pipe_ctl;

    // item after the state update
    typedef struct packed {
        t_wave              mode;
        logic [PHASE_W-1:0] phase;
        logic               changed;
    } t_s1;

    // item after the shape lookup
    typedef struct packed {
        t_wave            mode;
        logic [AMP_W-1:0] mag;
        logic             neg;
        logic             changed;
    } t_s2;

    // quarter wave sine, entries 0..128
    typedef logic [128:0][AMP_W-1:0] t_sine_qtr;

    localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C234;
    localparam logic [63:0] TAYLOR_DIV [13] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
        64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702
    };

    // (a*b) >> 62, low 64 bits
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // round(32767*sin(pi*r/256)) by a fixed point series, elaboration only
    function automatic logic [AMP_W-1:0] quarter_sine(input int unsigned r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] negs;
        logic [63:0] s;
        logic [63:0] v;
        logic [63:0] y;
        int          i;
        x    = (PI_Q62 >> 8) * 64'(r & 32'hFF);
        x2   = mul_q62(x, x);
        term = x;
        pos  = 64'd0;
        negs = 64'd0;
        for (i = 0; i < 13; i++) begin
            if ((i & 1) == 0) begin
                pos = pos + term;
            end else begin
                negs = negs + term;
            end
            term = mul_q62(term, x2) / TAYLOR_DIV[i];
        end
        s = (pos >= negs) ? pos - negs : 64'd0;
        v = s >> 22;
        y = (v * 64'd32767 + (64'd1 << 39)) >> 40;
        return y[AMP_W-1:0];
    endfunction

    function automatic t_sine_qtr build_sine_qtr();
        t_sine_qtr qtab;
        int        k;
        for (k = 0; k <= 128; k++) begin
            qtab[k] = quarter_sine(k);
        end
        return qtab;
    endfunction

    localparam t_sine_qtr SINE_QTR = build_sine_qtr();

endpackage

/* rtl/core/mwpg_state.sv */
`timescale 1ns / 1ps
module mwpg_state (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic [mwpg_pkg::ELAPSED_W-1:0]    i_elapsed_ms,
    input  mwpg_pkg::t_cfg                    i_cfg,
    input  mwpg_pkg::t_pipe_ctl               i_ctl,
    output logic                              o_s1_valid,
    output mwpg_pkg::t_s1                     o_s1
);

    logic [mwpg_pkg::TIMER_W-1:0] r_timer;
    logic [mwpg_pkg::TIMER_W-1:0] n_timer;
    mwpg_pkg::t_wave              r_mode;
    mwpg_pkg::t_wave              n_mode;
    logic [mwpg_pkg::PHASE_W-1:0] r_phase;
    logic [mwpg_pkg::PHASE_W-1:0] n_phase;
    logic                         r_s1_valid;
    mwpg_pkg::t_s1                r_s1;
    logic [mwpg_pkg::TIMER_W-1:0] sum;
    logic                         hit;
    logic                         fire;
    logic [mwpg_pkg::STEP_W-1:0]  step;
    logic [mwpg_pkg::PHASE_W-1:0] base;

    // a zero tick is taken but changes nothing
    assign fire = i_accept && (i_elapsed_ms != '0);

    // timer add and switch check
    assign sum = r_timer + {{(mwpg_pkg::TIMER_W-mwpg_pkg::ELAPSED_W){1'b0}}, i_elapsed_ms};
    assign hit = sum >= {{(mwpg_pkg::TIMER_W-mwpg_pkg::PERIOD_W){1'b0}}, i_cfg.period};

    always_comb begin
        n_mode = hit ? mwpg_pkg::t_wave'(r_mode + 2'd1) : r_mode;
        base   = hit ? '0 : r_phase;
        unique case (n_mode)
            mwpg_pkg::MODE_SLOW_SINE: step = i_cfg.slow_step;
            mwpg_pkg::MODE_FAST_SINE: step = i_cfg.fast_step;
            mwpg_pkg::MODE_TRIANGLE:  step = i_cfg.tri_step;
            mwpg_pkg::MODE_SQUARE:    step = i_cfg.square_step;
            default:                  step = i_cfg.square_step;
        endcase
        n_phase = base + step;
        n_timer = hit ? '0 : sum;
    end

    // generator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer <= '0;
            r_mode  <= mwpg_pkg::MODE_SLOW_SINE;
            r_phase <= '0;
        end else if (fire) begin
            r_timer <= n_timer;
            r_mode  <= n_mode;
            r_phase <= n_phase;
        end
    end

    // stage one register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_ctl.s1_load) begin
            r_s1_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s1_load) begin
            r_s1.mode    <= n_mode;
            r_s1.phase   <= n_phase;
            r_s1.changed <= hit;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

    // switch clears the timer
    a_switch_clears_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && hit) |=> (r_timer == '0))
        else $error("timer not cleared on waveform switch");

    // state holds without a nonzero tick
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> ($stable(r_timer) && $stable(r_mode) && $stable(r_phase)))
        else $error("generator state moved without a tick");

    // a zero tick never produces a stage one item
    a_zero_tick_no_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (i_elapsed_ms == '0)) |=> !r_s1_valid)
        else $error("zero tick produced an item");

endmodule

/* rtl/core/mwpg_shape.sv */
`timescale 1ns / 1ps
module mwpg_shape (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mwpg_pkg::t_pipe_ctl  i_ctl,
    input  logic                 i_s1_valid,
    input  mwpg_pkg::t_s1        i_s1,
    output logic                 o_s2_valid,
    output mwpg_pkg::t_s2        o_s2
);

    logic                        r_s2_valid;
    mwpg_pkg::t_s2               r_s2;
    mwpg_pkg::t_s2               n_s2;
    logic [6:0]                  low;
    logic [7:0]                  qidx;
    logic [7:0]                  rev;

    assign low  = i_s1.phase[6:0];
    assign rev  = 8'd128 - {1'b0, low};
    assign qidx = i_s1.phase[7] ? rev : {1'b0, low};

    // magnitude and sign for each waveform
    always_comb begin
        n_s2.mode    = i_s1.mode;
        n_s2.changed = i_s1.changed;
        case (i_s1.mode) inside
            mwpg_pkg::MODE_SLOW_SINE, mwpg_pkg::MODE_FAST_SINE: begin
                n_s2.mag = mwpg_pkg::SINE_QTR[qidx];
                n_s2.neg = i_s1.phase[8];
            end
            mwpg_pkg::MODE_TRIANGLE: begin
                // rising half below 256, falling half above
                if (i_s1.phase[7]) begin
                    n_s2.mag = {8'd0, low};
                    n_s2.neg = i_s1.phase[8];
                end else begin
                    n_s2.mag = {7'd0, rev};
                    n_s2.neg = !i_s1.phase[8];
                end
            end
            default: begin
                n_s2.mag = '0;
                n_s2.neg = i_s1.phase[8];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_ctl.s2_load) begin
            r_s2_valid <= i_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s2_load) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2_valid = r_s2_valid;
    assign o_s2       = r_s2;

endmodule

/* rtl/core/mwpg_scale.sv */
`timescale 1ns / 1ps
module mwpg_scale (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mwpg_pkg::t_pipe_ctl                  i_ctl,
    input  logic [mwpg_pkg::AMP_W-1:0]           i_amplitude,
    input  logic                                 i_s2_valid,
    input  mwpg_pkg::t_s2                        i_s2,
    output logic                                 o_valid,
    output logic signed [mwpg_pkg::SAMPLE_W-1:0] o_sample,
    output logic [1:0]                           o_wave_mode,
    output logic                                 o_mode_changed
);

    logic                                 r_valid;
    logic signed [mwpg_pkg::SAMPLE_W-1:0] r_sample;
    logic signed [mwpg_pkg::SAMPLE_W-1:0] n_sample;
    logic [1:0]                           r_mode;
    logic                                 r_changed;
    logic [2*mwpg_pkg::AMP_W-1:0]         prod;
    logic [mwpg_pkg::AMP_W-1:0]           res;
    logic [mwpg_pkg::SAMPLE_W-1:0]        res_ext;

    // amplitude scaling, sine by 1/32768 and triangle by 1/128; square uses the amplitude as is
    assign prod = {{mwpg_pkg::AMP_W{1'b0}}, i_s2.mag} * {{mwpg_pkg::AMP_W{1'b0}}, i_amplitude};

    always_comb begin
        case (i_s2.mode) inside
            mwpg_pkg::MODE_SLOW_SINE, mwpg_pkg::MODE_FAST_SINE: res = prod[29:15];
            mwpg_pkg::MODE_TRIANGLE:                            res = prod[21:7];
            default:                                            res = i_amplitude;
        endcase
        res_ext  = {1'b0, res};
        n_sample = i_s2.neg ? -$signed(res_ext) : $signed(res_ext);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.s3_load) begin
            r_valid <= i_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s3_load) begin
            r_sample  <= n_sample;
            r_mode    <= i_s2.mode;
            r_changed <= i_s2.changed;
        end
    end

    assign o_valid        = r_valid;
    assign o_sample       = r_sample;
    assign o_wave_mode    = r_mode;
    assign o_mode_changed = r_changed;

endmodule

/* rtl/core/multi_waveform_phase_generator.sv */
`timescale 1ns / 1ps
// a nonzero tick passes the stage one, stage two and output registers before o_valid rises
// throughput: one tick per cycle; a held output stalls the input once all three stages are full
// a tick of zero is taken and gives no sample
// reset (i_rst_n low, synchronous) restores register defaults, slow sine, phase and timer zero
// reset empties the pipeline; no clearing pass, the block is ready right after reset
module multi_waveform_phase_generator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [mwpg_pkg::ELAPSED_W-1:0]       i_elapsed_ms,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [mwpg_pkg::SAMPLE_W-1:0] o_sample,
    output logic [1:0]                           o_wave_mode,
    output logic                                 o_mode_changed,
    input  logic                                 i_cfg_we,
    input  logic [mwpg_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mwpg_pkg::CFG_DAT_W-1:0]       i_cfg_data
);

    mwpg_pkg::t_cfg      r_cfg;
    mwpg_pkg::t_pipe_ctl ctl;
    mwpg_pkg::t_s1       s1;
    mwpg_pkg::t_s2       s2;
    logic                s1_valid;
    logic                s2_valid;
    logic                accept;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.amplitude   <= mwpg_pkg::RST_AMPLITUDE;
            r_cfg.slow_step   <= mwpg_pkg::RST_SLOW_STEP;
            r_cfg.fast_step   <= mwpg_pkg::RST_FAST_STEP;
            r_cfg.tri_step    <= mwpg_pkg::RST_TRI_STEP;
            r_cfg.square_step <= mwpg_pkg::RST_SQR_STEP;
            r_cfg.period      <= mwpg_pkg::RST_PERIOD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mwpg_pkg::CFG_AMPLITUDE:   r_cfg.amplitude   <= i_cfg_data[14:0];
                mwpg_pkg::CFG_SLOW_STEP:   r_cfg.slow_step   <= i_cfg_data[8:0];
                mwpg_pkg::CFG_FAST_STEP:   r_cfg.fast_step   <= i_cfg_data[8:0];
                mwpg_pkg::CFG_TRI_STEP:    r_cfg.tri_step    <= i_cfg_data[8:0];
                mwpg_pkg::CFG_SQUARE_STEP: r_cfg.square_step <= i_cfg_data[8:0];
                mwpg_pkg::CFG_PERIOD:      r_cfg.period      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stall chain: a stage loads when it is empty or its content moves on
    always_comb begin
        ctl.s3_load = !o_valid || i_ready;
        ctl.s2_load = !s2_valid || ctl.s3_load;
        ctl.s1_load = !s1_valid || ctl.s2_load;
    end

    assign o_ready = ctl.s1_load;
    assign accept  = i_valid && o_ready;

    mwpg_state u_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_elapsed_ms (i_elapsed_ms),
        .i_cfg        (r_cfg),
        .i_ctl        (ctl),
        .o_s1_valid   (s1_valid),
        .o_s1         (s1)
    );

    mwpg_shape u_shape (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_s1_valid (s1_valid),
        .i_s1       (s1),
        .o_s2_valid (s2_valid),
        .o_s2       (s2)
    );

    mwpg_scale u_scale (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_amplitude    (r_cfg.amplitude),
        .i_s2_valid     (s2_valid),
        .i_s2           (s2),
        .o_valid        (o_valid),
        .o_sample       (o_sample),
        .o_wave_mode    (o_wave_mode),
        .o_mode_changed (o_mode_changed)
    );

endmodule
